// ===== hdl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define XED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// condition holds in the cycle after the trigger
`define XED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== hdl/xed_pkg.sv =====
// types, constants and name tables of the entity decoder
package xed_pkg;

  localparam int CHAR_W    = 16;
  localparam int MAX_TOKEN = 16;
  localparam int TOK_IDX_W = $clog2(MAX_TOKEN);
  localparam int TOK_CNT_W = $clog2(MAX_TOKEN + 1);
  localparam int NUM_W     = 17;
  localparam int NUM_SUM_W = NUM_W + 5;
  localparam logic [NUM_W-1:0] NUM_LIMIT = 17'h1FFFF;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int NUM_NAMES = 5;

  // character codes
  localparam logic [CHAR_W-1:0] CH_AMP  = 16'h0026;
  localparam logic [CHAR_W-1:0] CH_SEMI = 16'h003B;
  localparam logic [CHAR_W-1:0] CH_HASH = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_X    = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_LT   = 16'h003C;
  localparam logic [CHAR_W-1:0] CH_GT   = 16'h003E;
  localparam logic [CHAR_W-1:0] CH_APOS = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_QUOT = 16'h0022;

  // one command from front to back: flush held token, then maybe one word
  typedef struct packed {
    logic [TOK_CNT_W-1:0] flush_len;
    logic                 has_char;
    logic [CHAR_W-1:0]    ch;
    logic                 last;
  } cmd_t;

  // token store write port
  typedef struct packed {
    logic                 en;
    logic [TOK_IDX_W-1:0] addr;
    logic [CHAR_W-1:0]    data;
  } tok_wr_t;

  typedef struct packed {
    logic flush_pend;
  } front_status_t;

  typedef struct packed {
    logic flushing;
    logic flush_done;
  } back_status_t;

  // named reference lengths, without the semicolon
  function automatic logic [2:0] name_len(input int k);
    logic [2:0] r;
    case (k)
      0:       r = 3'd3;
      1:       r = 3'd2;
      2:       r = 3'd2;
      3:       r = 3'd4;
      4:       r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // lower-case letter at a position of a named reference
  function automatic logic [7:0] name_char(input int k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      0: case (pos)
           3'd0:    r = 8'h61; // a
           3'd1:    r = 8'h6D; // m
           3'd2:    r = 8'h70; // p
           default: r = 8'h00;
         endcase
      1: case (pos)
           3'd0:    r = 8'h6C; // l
           3'd1:    r = 8'h74; // t
           default: r = 8'h00;
         endcase
      2: case (pos)
           3'd0:    r = 8'h67; // g
           3'd1:    r = 8'h74; // t
           default: r = 8'h00;
         endcase
      3: case (pos)
           3'd0:    r = 8'h61; // a
           3'd1:    r = 8'h70; // p
           3'd2:    r = 8'h6F; // o
           3'd3:    r = 8'h73; // s
           default: r = 8'h00;
         endcase
      4: case (pos)
           3'd0:    r = 8'h71; // q
           3'd1:    r = 8'h75; // u
           3'd2:    r = 8'h6F; // o
           3'd3:    r = 8'h74; // t
           default: r = 8'h00;
         endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // decoded character of a named reference
  function automatic logic [CHAR_W-1:0] name_val(input int k);
    logic [CHAR_W-1:0] r;
    case (k)
      0:       r = CH_AMP;
      1:       r = CH_LT;
      2:       r = CH_GT;
      3:       r = CH_APOS;
      4:       r = CH_QUOT;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/xml_entity_decoder_unit.sv =====
// top level of the xml character and entity reference decoder
// Input channel: one 16-bit word per item (in_char) with in_last on the final
// word of a string. Output channel: decoded or passed-through words, out_last
// on the final word of the string. Both use valid/ready.
// Plain text moves one word per cycle while out_ready is high; a taken word passes
// the command queue and the back's command register before the output register.
// Words after '&' are held and give no output until ';', another '&', the end
// of the string or a full 16-entry store ends the reference. A decoded
// reference yields one word. A reference that does not decode is replayed
// from the token store one word per cycle while out_ready is high (up to 16, plus the ending word);
// input is held off from that command's issue until the store has been read.
// A 4-entry command queue sits between the classifying front and the back,
// so the front keeps taking words while the back waits on a stalled receiver;
// when the receiver holds out_ready low the queue fills and in_ready drops.
// Reset (rst_n low, synchronous) drops any open reference and empties the
// queue and output register; the store contents need no clearing.
`include "assert_macros.svh"

module xml_entity_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char,
  output logic        out_last
);

  logic                          q_push, q_pop, q_full, q_empty;
  xed_pkg::cmd_t                 q_wdata, q_rdata;
  xed_pkg::tok_wr_t              tok_wr;
  logic [xed_pkg::TOK_IDX_W-1:0] rd_addr;
  logic [xed_pkg::CHAR_W-1:0]    rd_data;
  xed_pkg::front_status_t        fr_st;
  xed_pkg::back_status_t         bk_st;

  // classify and track references
  xed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full),
    .tok_wr   (tok_wr),
    .bk_st    (bk_st),
    .fr_st    (fr_st)
  );

  // held reference characters
  xed_tok_buf u_tok_buf (
    .clk     (clk),
    .wr      (tok_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // command queue
  xed_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // emit words
  xed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .bk_st     (bk_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // store must stay frozen while the back replays it
  `XED_ASSERT_IMP(a_no_input_during_flush, bk_st.flushing, !in_ready)
  // a replay only finishes for a flush the front is waiting on
  `XED_ASSERT_IMP(a_done_only_when_pending, bk_st.flush_done, fr_st.flush_pend)
  // end of a replay releases the front
  `XED_ASSERT_NXT(a_pend_released, bk_st.flush_done, !fr_st.flush_pend)
  // queue never takes a command while full
  `XED_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)

endmodule

// ===== hdl/xed_tok_buf.sv =====
// token store: held characters of the open reference
module xed_tok_buf (
  input  logic                             clk,
  input  xed_pkg::tok_wr_t                 wr,
  input  logic [xed_pkg::TOK_IDX_W-1:0]    rd_addr,
  output logic [xed_pkg::CHAR_W-1:0]       rd_data
);

  logic [xed_pkg::CHAR_W-1:0] store_r [xed_pkg::MAX_TOKEN];
  logic [xed_pkg::CHAR_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  // one write port from the front
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr.addr] <= wr.data;
    end
  end

  // one registered read port for the back
  always_ff @(posedge clk) begin
    rd_data_r <= store_r[rd_addr];
  end

endmodule

// ===== hdl/xed_cmd_fifo.sv =====
// short command queue between front and back
module xed_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  xed_pkg::cmd_t        push_data,
  output logic                 full,
  input  logic                 pop,
  output xed_pkg::cmd_t        pop_data,
  output logic                 empty
);

  xed_pkg::cmd_t                   mem_r [xed_pkg::Q_DEPTH];
  xed_pkg::cmd_t                   pop_data_r;
  logic [xed_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [xed_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [xed_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == xed_pkg::Q_CNT_W'(xed_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = pop_data_r;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage and registered head, a word pushed into the head slot goes straight through
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      pop_data_r <= push_data;
    end else begin
      pop_data_r <= mem_r[rd_ptr_nxt];
    end
  end

endmodule

// ===== hdl/xed_front.sv =====
// front: takes input words, tracks the open reference and issues commands
module xed_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [xed_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_last,
  output logic                          q_push,
  output xed_pkg::cmd_t                 q_data,
  input  logic                          q_full,
  output xed_pkg::tok_wr_t              tok_wr,
  input  xed_pkg::back_status_t         bk_st,
  output xed_pkg::front_status_t        fr_st
);

  logic [xed_pkg::TOK_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;
  logic                           is_num_r, hex_r, num_ok_r;
  logic [xed_pkg::NUM_W-1:0]      num_r;
  logic [xed_pkg::NUM_NAMES-1:0]  nm_r;

  logic                           accept;
  logic                           start, store;
  logic                           is_upper;
  logic [xed_pkg::CHAR_W-1:0]     folded;
  logic [xed_pkg::NUM_NAMES-1:0]  nm_step, name_hit;
  logic [xed_pkg::CHAR_W-1:0]     name_dec;
  logic                           dec_dig, lo_hex, up_hex, is_dig;
  logic [3:0]                     digit;
  logic [xed_pkg::NUM_SUM_W-1:0]  prod, sum;
  logic                           ovf;
  logic                           decode;
  logic [xed_pkg::CHAR_W-1:0]     dec_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full && !pend_r;
  assign fr_st.flush_pend = pend_r;

  // case fold and named reference tracking
  always_comb begin
    is_upper = (in_char >= 16'h0041) && (in_char <= 16'h005A);
    folded   = is_upper ? in_char + 16'd32 : in_char;
    name_dec = '0;
    for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
      nm_step[k]  = nm_r[k]
                 && (cnt_r <= xed_pkg::TOK_CNT_W'(xed_pkg::name_len(k)))
                 && (folded == xed_pkg::CHAR_W'(xed_pkg::name_char(k, 3'(cnt_r - 1'b1))));
      name_hit[k] = nm_r[k]
                 && (cnt_r == xed_pkg::TOK_CNT_W'(xed_pkg::name_len(k)) + 1'b1);
      if (name_hit[k]) begin
        name_dec = name_dec | xed_pkg::name_val(k);
      end
    end
  end

  // numeric reference digit step
  always_comb begin
    dec_dig = (in_char >= 16'h0030) && (in_char <= 16'h0039);
    lo_hex  = hex_r && (in_char >= 16'h0061) && (in_char <= 16'h0066);
    up_hex  = hex_r && (in_char >= 16'h0041) && (in_char <= 16'h0046);
    is_dig  = dec_dig || lo_hex || up_hex;
    digit   = dec_dig ? in_char[3:0] : in_char[3:0] + 4'd9;
    prod    = hex_r ? {1'b0, num_r, 4'b0000}
                    : ({2'b00, num_r, 3'b000} + {4'b0000, num_r, 1'b0});
    sum     = prod + xed_pkg::NUM_SUM_W'(digit);
    ovf     = sum > xed_pkg::NUM_SUM_W'(xed_pkg::NUM_LIMIT);
  end

  // outcome of a closing semicolon
  always_comb begin
    if (is_num_r) begin
      decode  = num_ok_r && (num_r != '0);
      dec_val = num_r[xed_pkg::CHAR_W-1:0];
    end else begin
      decode  = |name_hit;
      dec_val = name_dec;
    end
  end

  // per-word action
  always_comb begin
    q_push  = 1'b0;
    q_data  = '0;
    tok_wr  = '0;
    cnt_nxt = cnt_r;
    start   = 1'b0;
    store   = 1'b0;
    if (accept) begin
      if (cnt_r == '0) begin
        if (in_char == xed_pkg::CH_AMP && !in_last) begin
          cnt_nxt = xed_pkg::TOK_CNT_W'(1);
          start   = 1'b1;
        end else begin
          q_push          = 1'b1;
          q_data.has_char = 1'b1;
          q_data.ch       = in_char;
          q_data.last     = in_last;
        end
      end else if (in_char == xed_pkg::CH_SEMI) begin
        cnt_nxt         = '0;
        q_push          = 1'b1;
        q_data.has_char = 1'b1;
        q_data.last     = in_last;
        if (decode) begin
          q_data.ch = dec_val;
        end else begin
          q_data.flush_len = cnt_r;
          q_data.ch        = xed_pkg::CH_SEMI;
        end
      end else if (in_char == xed_pkg::CH_AMP) begin
        q_push           = 1'b1;
        q_data.flush_len = cnt_r;
        if (in_last) begin
          q_data.has_char = 1'b1;
          q_data.ch       = xed_pkg::CH_AMP;
          q_data.last     = 1'b1;
          cnt_nxt         = '0;
        end else begin
          cnt_nxt = xed_pkg::TOK_CNT_W'(1);
          start   = 1'b1;
        end
      end else if (cnt_r >= xed_pkg::TOK_CNT_W'(xed_pkg::MAX_TOKEN) || in_last) begin
        q_push           = 1'b1;
        q_data.flush_len = cnt_r;
        q_data.has_char  = 1'b1;
        q_data.ch        = in_char;
        q_data.last      = in_last;
        cnt_nxt          = '0;
      end else begin
        store       = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        tok_wr.en   = 1'b1;
        tok_wr.addr = cnt_r[xed_pkg::TOK_IDX_W-1:0];
        tok_wr.data = in_char;
      end
    end
  end

  // a flush freezes input until the back has read the store
  always_comb begin
    if (pend_r) begin
      pend_nxt = !bk_st.flush_done;
    end else begin
      pend_nxt = q_push && (q_data.flush_len != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // classification state of the open reference
  always_ff @(posedge clk) begin
    if (start) begin
      is_num_r <= 1'b0;
      hex_r    <= 1'b0;
      num_ok_r <= 1'b1;
      num_r    <= '0;
      nm_r     <= '1;
    end else if (store) begin
      nm_r <= nm_step;
      if (cnt_r == xed_pkg::TOK_CNT_W'(1)) begin
        is_num_r <= (in_char == xed_pkg::CH_HASH);
      end else if (is_num_r) begin
        if (cnt_r == xed_pkg::TOK_CNT_W'(2) && in_char == xed_pkg::CH_X) begin
          hex_r <= 1'b1;
        end else if (!is_dig || ovf) begin
          num_ok_r <= 1'b0;
        end else begin
          num_r <= sum[xed_pkg::NUM_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hdl/xed_back.sv =====
// back: runs commands, replays held tokens and drives the output register
module xed_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  xed_pkg::cmd_t                 q_data,
  output logic                          q_pop,
  output logic [xed_pkg::TOK_IDX_W-1:0] rd_addr,
  input  logic [xed_pkg::CHAR_W-1:0]    rd_data,
  output xed_pkg::back_status_t         bk_st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xed_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CHAR
  } state_t;

  state_t                          state_r, state_nxt;
  xed_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [xed_pkg::TOK_CNT_W-1:0]   idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [xed_pkg::CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            can_load, fire, fin, end_flush;
  logic [xed_pkg::CHAR_W-1:0]      elem_char;
  logic                            elem_last;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  // store read is registered, so it is addressed with the next index
  assign rd_addr   = idx_nxt[xed_pkg::TOK_IDX_W-1:0];

  // current element of the running command
  always_comb begin
    can_load  = !out_valid_r || out_ready;
    fire      = (state_r != ST_IDLE) && can_load;
    end_flush = (idx_r == cmd_r.flush_len - 1'b1);
    case (state_r)
      ST_FLUSH: begin
        elem_char = (idx_r == '0) ? xed_pkg::CH_AMP : rd_data;
        elem_last = cmd_r.last && !cmd_r.has_char && end_flush;
        fin       = end_flush && !cmd_r.has_char;
      end
      ST_CHAR: begin
        elem_char = cmd_r.ch;
        elem_last = cmd_r.last;
        fin       = 1'b1;
      end
      default: begin
        elem_char = '0;
        elem_last = 1'b0;
        fin       = 1'b0;
      end
    endcase
    q_pop            = !q_empty && ((state_r == ST_IDLE) || (fire && fin));
    bk_st.flushing   = (state_r == ST_FLUSH);
    bk_st.flush_done = fire && (state_r == ST_FLUSH) && end_flush;
  end

  // sequencing and output register
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (can_load) begin
      out_valid_nxt = fire;
      if (fire) begin
        out_char_nxt = elem_char;
        out_last_nxt = elem_last;
      end
    end
    if (fire) begin
      if (state_r == ST_FLUSH && !end_flush) begin
        idx_nxt = idx_r + 1'b1;
      end else if (state_r == ST_FLUSH && cmd_r.has_char) begin
        state_nxt = ST_CHAR;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
    if (q_pop) begin
      cmd_nxt   = q_data;
      idx_nxt   = '0;
      state_nxt = (q_data.flush_len != '0) ? ST_FLUSH : ST_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the xml character and entity reference decoder
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_WORDS = 125;
  localparam int DRAIN_CYCLES = 40;

  // character codes used by the decoder check
  localparam logic [xed_pkg::CHAR_W-1:0] CH_0  = 16'h0030;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_9  = 16'h0039;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_LA = 16'h0061;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_LF = 16'h0066;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_UA = 16'h0041;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_UF = 16'h0046;
  localparam logic [xed_pkg::CHAR_W-1:0] CH_UZ = 16'h005A;

  typedef struct packed {
    logic [xed_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_char = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_char;
  logic        out_last;

  xml_entity_decoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .out_last (out_last)
  );

  // stimulus and expectations
  word_t send_q[$];
  word_t want_q[$];
  word_t burst_q[$];
  logic [xed_pkg::CHAR_W-1:0] line_q[$];
  string ref_names[8] = '{"amp", "lt", "gt", "apos", "quot", "am", "ampx", "nbsp"};

  // decoder state mirror
  logic [xed_pkg::CHAR_W-1:0] held [xed_pkg::MAX_TOKEN];
  int unsigned held_n = 0;

  // bookkeeping
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int lines_sent = 0;
  int n_decoded = 0;
  int n_replayed = 0;
  int n_backpressure = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int rx_cycles = 0;
  logic tail = 1'b0;
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;
  word_t cur;
  word_t head;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------

  function automatic logic [xed_pkg::CHAR_W-1:0] lower_of(logic [xed_pkg::CHAR_W-1:0] c);
    if (c >= CH_UA && c <= CH_UZ) return c + 16'd32;
    return c;
  endfunction

  // held word 1 onward against a reference name, semicolon excluded
  function automatic bit name_hit(string nm);
    int i;
    if (held_n != nm.len() + 1) return 1'b0;
    for (i = 0; i < nm.len(); i++)
      if (lower_of(held[i + 1]) != {8'h00, nm[i]}) return 1'b0;
    return 1'b1;
  endfunction

  // numeric reference value, decimal or lower-case x hex
  function automatic bit num_value(output logic [xed_pkg::CHAR_W-1:0] v);
    int unsigned i;
    logic [31:0] n;
    logic [31:0] d;
    logic [xed_pkg::CHAR_W-1:0] c;
    bit hex;
    v = '0;
    n = '0;
    hex = (held_n > 2) && (held[2] == xed_pkg::CH_X);
    i = hex ? 3 : 2;
    while (i < held_n) begin
      c = held[i];
      if (c >= CH_0 && c <= CH_9) d = 32'(c - CH_0);
      else if (hex && c >= CH_LA && c <= CH_LF) d = 32'(c - CH_LA) + 32'd10;
      else if (hex && c >= CH_UA && c <= CH_UF) d = 32'(c - CH_UA) + 32'd10;
      else return 1'b0;
      n = n * (hex ? 32'd16 : 32'd10) + d;
      if (n > 32'(xed_pkg::NUM_LIMIT)) return 1'b0;
      i++;
    end
    if (n == 0) return 1'b0;
    v = n[xed_pkg::CHAR_W-1:0];
    return 1'b1;
  endfunction

  // replay the held token verbatim
  task automatic spill_held();
    int unsigned i;
    for (i = 0; i < held_n && i < xed_pkg::MAX_TOKEN; i++)
      burst_q.push_back('{held[i], 1'b0});
    held_n = 0;
    n_replayed++;
  endtask

  // expected output words for one accepted input word
  task automatic decode_word(input logic [xed_pkg::CHAR_W-1:0] c, input logic last);
    logic [xed_pkg::CHAR_W-1:0] v;
    bit ok;
    burst_q.delete();
    v = '0;
    if (held_n == 0) begin
      if (c == xed_pkg::CH_AMP && !last) begin
        held[0] = c;
        held_n = 1;
      end else begin
        burst_q.push_back('{c, 1'b0});
      end
    end else if (c == xed_pkg::CH_SEMI) begin
      ok = 1'b1;
      if (held_n >= 2 && held[1] == xed_pkg::CH_HASH) ok = num_value(v);
      else if (name_hit("amp")) v = xed_pkg::CH_AMP;
      else if (name_hit("lt")) v = xed_pkg::CH_LT;
      else if (name_hit("gt")) v = xed_pkg::CH_GT;
      else if (name_hit("apos")) v = xed_pkg::CH_APOS;
      else if (name_hit("quot")) v = xed_pkg::CH_QUOT;
      else ok = 1'b0;
      if (ok) begin
        held_n = 0;
        n_decoded++;
        burst_q.push_back('{v, 1'b0});
      end else begin
        spill_held();
        burst_q.push_back('{c, 1'b0});
      end
    end else if (c == xed_pkg::CH_AMP) begin
      // a new ampersand ends the open reference
      spill_held();
      if (last) begin
        burst_q.push_back('{c, 1'b0});
      end else begin
        held[0] = c;
        held_n = 1;
      end
    end else if (held_n >= xed_pkg::MAX_TOKEN || last) begin
      // full store or end of string
      spill_held();
      burst_q.push_back('{c, 1'b0});
    end else begin
      held[held_n] = c;
      held_n++;
    end
    if (last && burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) want_q.push_back(burst_q[i]);
  endtask

  // ---------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------

  task automatic add_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back({8'h00, s[i]});
  endtask

  task automatic add_letters(int n);
    repeat (n) line_q.push_back(16'(CH_LA + $urandom_range(0, 25)));
  endtask

  // queue the current string, last flag on its final word when with_last is set
  task automatic end_line(bit with_last);
    int i;
    for (i = 0; i < line_q.size(); i++)
      send_q.push_back('{line_q[i], with_last && (i == line_q.size() - 1)});
    line_q.delete();
    lines_sent++;
  endtask

  function automatic string mix_case(string s);
    string r;
    int i;
    r = s;
    for (i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) r[i] = r[i] - 8'd32;
    return r;
  endfunction

  // reference values around the decode limits
  function automatic int pick_num();
    int v;
    case ($urandom_range(0, 6))
      0:       v = $urandom_range(1, 127);
      1:       v = $urandom_range(128, 32'h1FFFF);
      2:       v = 0;
      3:       v = $urandom_range(32'h20000, 32'h3FFFF);
      4:       v = 32'h10000;
      5:       v = 32'h1FFFF;
      default: v = 32'h20000;
    endcase
    return v;
  endfunction

  // one random string built from text and references
  task automatic gen_line();
    string s;
    string mark;
    if ($urandom_range(0, 6) == 0) begin
      // raw words over the whole code range
      repeat ($urandom_range(1, 8)) line_q.push_back(16'($urandom_range(0, 16'hFFFF)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 7))
          0, 1: begin
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 2) == 0)
                line_q.push_back(16'($urandom_range(0, 16'hFFFF)));
              else line_q.push_back(16'(CH_LA + $urandom_range(0, 25)));
            end
          end
          2: add_str({"&", mix_case(ref_names[$urandom_range(0, 7)]), ";"});
          3: begin
            s = $sformatf("%0d", pick_num());
            if ($urandom_range(0, 3) == 0) s = {"0", s};
            add_str({"&#", s, ";"});
          end
          4: begin
            s = mix_case($sformatf("%0h", pick_num()));
            mark = ($urandom_range(0, 9) == 0) ? "X" : "x";
            add_str({"&#", mark, s, ";"});
          end
          5: begin
            case ($urandom_range(0, 4))
              0:       add_str("&#;");
              1:       add_str("&#x;");
              2:       add_str("&#X41;");
              3:       add_str("&#1g;");
              default: add_str("&#xq1;");
            endcase
          end
          6: begin
            // reference of 14 to 18 letters, around the size of the token store
            add_str("&");
            add_letters($urandom_range(14, 18));
            if ($urandom_range(0, 1) == 1) add_str(";");
          end
          default: begin
            // reference left open
            add_str("&");
            add_letters($urandom_range(0, 4));
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0) add_str("&");
    end
    end_line(1'b1);
  endtask

  // ---------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_ready) n_backpressure++;
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          decode_word(in_char, in_last);
          words_in++;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur = send_q.pop_front();
          in_valid <= 1'b1;
          in_char <= cur.ch;
          in_last <= cur.last;
          if (send_q.size() >= 30 && (words_in / 40) % 2 == 0 && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail <= (send_q.size() < 30);
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_on <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_on) begin
      if (hold_cnt == HOLD_CYCLES) begin
        hold_on <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else if (!hold_done && words_in >= 60) begin
      hold_on <= 1'b1;
      hold_cnt <= 0;
    end
  end

  // ---------------------------------------------------------------
  // receiver
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (hold_on) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!tail && (rx_cycles / 300) % 2 == 0 && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  // output check against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output word: char %h last %b", out_char, out_last);
      end else begin
        head = want_q.pop_front();
        if (out_char !== head.ch || out_last !== head.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on output word %0d: char %h want %h, last %b want %b",
                     words_out, out_char, head.ch, out_last, head.last);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, want_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    int n_directed;
    // field extremes
    line_q.push_back(16'h0000);
    end_line(1'b0);
    line_q.push_back(16'hFFFF);
    end_line(1'b1);
    // ampersand inside a reference, then ampersand as the final word
    add_str("&&");
    end_line(1'b1);
    // case folded name
    add_str("&LT;");
    end_line(1'b0);
    // end of string inside a reference
    add_str("&a");
    end_line(1'b1);
    // empty number
    add_str("&#;");
    end_line(1'b0);
    // value that truncates to zero
    add_str("&#x10000;");
    end_line(1'b1);
    // lone ampersand as the final word
    add_str("&");
    end_line(1'b1);
    n_directed = send_q.size();
    while (send_q.size() < n_directed + RANDOM_WORDS) gen_line();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (send_q.size() != 0 || in_valid);
    do @(posedge clk); while (want_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d strings, checked %0d output words",
             words_in, lines_sent, words_out);
    $display("references decoded %0d, replayed verbatim %0d, input stalled %0d cycles",
             n_decoded, n_replayed, n_backpressure);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
